>>> hw/rtl/cicpi_pkg.sv
// Package: widths, filter coefficient table and lane control type for the CIC interpolator.
`timescale 1ns / 1ps
`default_nettype none
package cicpi_pkg;

  localparam int CIC_ORDER   = 8;
  localparam int RATE_FACTOR = 4;
  localparam int CHANNELS    = 4;
  localparam int SAMPLE_W    = 16;
  localparam int TIME_W      = 40;
  localparam int COEF_W      = 16;
  localparam int DIGIT_W     = 4;
  localparam int NUM_DIGITS  = COEF_W / DIGIT_W;
  localparam int ACC_W       = 32;
  localparam int SCALE_SH    = 14;
  localparam int RING_DEPTH  = CIC_ORDER;
  localparam int TAP_COUNT   = CIC_ORDER * (RATE_FACTOR - 1) + 1;
  localparam int TAB_LEN     = CIC_ORDER * RATE_FACTOR;
  localparam int FILL_ITEMS  = CIC_ORDER + 1;

  localparam logic [TIME_W-1:0] GROUP_DELAY = TIME_W'(12);

  typedef logic [COEF_W-1:0] coef_tab_t [TAB_LEN];
  typedef logic [CHANNELS-1:0][SAMPLE_W-1:0] sample_set_t;

  typedef struct packed {
    logic en;
    logic first;
    logic last;
    logic clear;
  } lane_ctl_t;

  // prototype = ones(RATE_FACTOR) convolved CIC_ORDER times, zero past the end
  function automatic coef_tab_t build_coef();
    int p [TAB_LEN];
    int t [TAB_LEN];
    coef_tab_t r;
    int len;
    for (int i = 0; i < TAB_LEN; i++) p[i] = 0;
    p[0] = 1;
    len = 1;
    for (int n = 0; n < CIC_ORDER; n++) begin
      for (int i = 0; i < TAB_LEN; i++) t[i] = 0;
      for (int i = 0; i < len; i++)
        for (int s = 0; s < RATE_FACTOR; s++)
          if (i + s < TAP_COUNT) t[i + s] += p[i];
      len += RATE_FACTOR - 1;
      for (int i = 0; i < TAB_LEN; i++) p[i] = t[i];
    end
    for (int i = 0; i < TAB_LEN; i++) r[i] = COEF_W'(p[i]);
    return r;
  endfunction

  localparam coef_tab_t COEF_TAB = build_coef();

endpackage
`default_nettype wire

>>> hw/rtl/cic_polyphase_interpolator_x4_unit.sv
// Top level: ring of sample sets, tap sequencer and four digit-serial lanes.
//
// Input channel in_*: one timestamped set of four signed samples per transfer.
// Result channel out_*: four results per input once the ring is primed,
// result 0 first; out_last_of_run marks the fourth.
// The first nine inputs only fill the ring and give no result.
// Each result walks 8 taps oldest first; every tap multiplies by the 16-bit
// coefficient 4 bits a cycle; the walk starts after the input transfer or after
// the previous result transfer, and a flush state then adds the last term to
// the accumulator before the result is shown.
// A filling input is stored without leaving the idle state.
// One item is in flight at a time: in_stall is high from the transfer until
// the fourth result has been taken.
// A stalled result holds its payload until transferred; the lanes wait.
// Reset (rst_n low, synchronous) empties the ring bookkeeping and drops
// any run in progress; ring contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module cic_polyphase_interpolator_x4_unit
  import cicpi_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [TIME_W-1:0]          in_time_tick,
  input  wire logic signed [SAMPLE_W-1:0] in_accel_x,
  input  wire logic signed [SAMPLE_W-1:0] in_accel_y,
  input  wire logic signed [SAMPLE_W-1:0] in_accel_z,
  input  wire logic signed [SAMPLE_W-1:0] in_accel_mag,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [TIME_W-1:0]               out_time,
  output logic signed [SAMPLE_W-1:0]      out_x,
  output logic signed [SAMPLE_W-1:0]      out_y,
  output logic signed [SAMPLE_W-1:0]      out_z,
  output logic signed [SAMPLE_W-1:0]      out_mag,
  output logic                            out_last_of_run
);

  localparam int PTR_W  = $clog2(RING_DEPTH);
  localparam int K_W    = $clog2(RATE_FACTOR);
  localparam int D_W    = $clog2(NUM_DIGITS);
  localparam int FILL_W = $clog2(FILL_ITEMS + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_MAC   = 4'b0010,
    S_FLUSH = 4'b0100,
    S_OUT   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  sample_set_t ring_r [RING_DEPTH];
  logic [PTR_W-1:0]  wp_r, wp_nxt, rd_r, rd_nxt, j_r, j_nxt;
  logic [K_W-1:0]    k_r, k_nxt;
  logic [D_W-1:0]    d_r, d_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [COEF_W-1:0] coef_sr_r, coef_sr_nxt;
  logic [TIME_W-1:0] time_r, time_nxt;
  logic [COEF_W-1:0] coef;
  logic [DIGIT_W-1:0] digit;
  logic in_xfer, out_xfer, k_last;
  lane_ctl_t ctl;
  sample_set_t rd_set, wr_set;
  logic signed [SAMPLE_W-1:0] res [CHANNELS];

  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_valid = (state_r == S_OUT);
  assign out_xfer  = out_valid && !out_stall;
  assign k_last    = (k_r == K_W'(RATE_FACTOR - 1));

  assign wr_set = {in_accel_mag, in_accel_z, in_accel_y, in_accel_x};
  assign rd_set = ring_r[rd_r];

  // tap j of phase k uses prototype index (RATE_FACTOR-1-k) + RATE_FACTOR*j
  assign coef  = COEF_TAB[{j_r, ~k_r}];
  assign digit = (d_r == '0) ? coef[COEF_W-1 -: DIGIT_W] : coef_sr_r[COEF_W-1 -: DIGIT_W];

  always_comb begin
    state_nxt   = state_r;
    wp_nxt      = wp_r;
    rd_nxt      = rd_r;
    j_nxt       = j_r;
    k_nxt       = k_r;
    d_nxt       = d_r;
    fill_nxt    = fill_r;
    coef_sr_nxt = coef_sr_r << DIGIT_W;
    time_nxt    = time_r;
    ctl         = '0;
    if (d_r == '0) coef_sr_nxt = coef << DIGIT_W;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          wp_nxt = wp_r + 1'b1;
          if (fill_r < FILL_W'(FILL_ITEMS)) begin
            fill_nxt = fill_r + 1'b1;
          end else begin
            rd_nxt    = wp_r + 1'b1;
            j_nxt     = '0;
            k_nxt     = '0;
            d_nxt     = '0;
            time_nxt  = in_time_tick - GROUP_DELAY;
            ctl.clear = 1'b1;
            state_nxt = S_MAC;
          end
        end
      end
      S_MAC: begin
        ctl.en    = 1'b1;
        ctl.first = (d_r == '0);
        ctl.last  = (d_r == D_W'(NUM_DIGITS - 1));
        d_nxt     = d_r + 1'b1;
        if (ctl.last) begin
          j_nxt  = j_r + 1'b1;
          rd_nxt = rd_r + 1'b1;
          if (j_r == PTR_W'(RING_DEPTH - 1)) state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_xfer) begin
          if (k_last) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt     = k_r + 1'b1;
            time_nxt  = time_r + 1'b1;
            rd_nxt    = wp_r;
            j_nxt     = '0;
            d_nxt     = '0;
            ctl.clear = 1'b1;
            state_nxt = S_MAC;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_xfer) ring_r[wp_r] <= wr_set;
    coef_sr_r <= coef_sr_nxt;
    time_r    <= time_nxt;
    rd_r      <= rd_nxt;
    j_r       <= j_nxt;
    d_r       <= d_nxt;
    if (!rst_n) begin
      state_r <= S_IDLE;
      wp_r    <= '0;
      fill_r  <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      wp_r    <= wp_nxt;
      fill_r  <= fill_nxt;
      k_r     <= k_nxt;
    end
  end

  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    cicpi_lane u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (ctl),
      .sample (rd_set[c]),
      .digit  (digit),
      .result (res[c])
    );
  end

  assign out_time        = time_r;
  assign out_x           = res[0];
  assign out_y           = res[1];
  assign out_z           = res[2];
  assign out_mag         = res[3];
  assign out_last_of_run = k_last;

endmodule
`default_nettype wire

>>> hw/rtl/cicpi_lane.sv
// One channel lane: digit-serial multiply-accumulate, rounding and saturation.
`timescale 1ns / 1ps
`default_nettype none
module cicpi_lane
  import cicpi_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire lane_ctl_t                  ctl,
  input  wire logic signed [SAMPLE_W-1:0] sample,
  input  wire logic [DIGIT_W-1:0]         digit,
  output logic signed [SAMPLE_W-1:0]      result
);

  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (SCALE_SH - 1);
  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'((1 << (SAMPLE_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SAT_MIN = -(ACC_W'(1) <<< (SAMPLE_W - 1));

  logic signed [SAMPLE_W+DIGIT_W:0] prod;
  logic signed [ACC_W-1:0] term_r, term_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic add_r;
  logic signed [ACC_W-1:0] rnd, q;

  assign prod = sample * $signed({1'b0, digit});

  always_comb begin
    term_nxt = term_r;
    if (ctl.en) begin
      term_nxt = (ctl.first ? '0 : (term_r <<< DIGIT_W)) + ACC_W'(prod);
    end
    acc_nxt = acc_r;
    if (ctl.clear) begin
      acc_nxt = '0;
    end else if (add_r) begin
      acc_nxt = acc_r + term_r;
    end
  end

  always_ff @(posedge clk) begin
    term_r <= term_nxt;
    acc_r  <= acc_nxt;
    if (!rst_n) begin
      add_r <= 1'b0;
    end else begin
      add_r <= ctl.en & ctl.last;
    end
  end

  assign rnd = acc_r + ROUND_HALF;
  assign q   = rnd >>> SCALE_SH;

  always_comb begin
    if (q > SAT_MAX) begin
      result = SAT_MAX[SAMPLE_W-1:0];
    end else if (q < SAT_MIN) begin
      result = SAT_MIN[SAMPLE_W-1:0];
    end else begin
      result = q[SAMPLE_W-1:0];
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/cicpi_port_chk.sv
// Port checker for the CIC interpolator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module cicpi_port_chk
  import cicpi_pkg::*;
(
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_stall,
  input wire logic                       out_valid,
  input wire logic                       out_stall,
  input wire logic [TIME_W-1:0]          out_time,
  input wire logic signed [SAMPLE_W-1:0] out_x,
  input wire logic                       out_last_of_run
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_time) && $stable(out_x))
    else $error("stalled result changed");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while a result is pending");

  a_mac_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_of_run |=> !out_valid)
    else $error("next result shown without computation");

  a_in_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !out_valid)
    else $error("result shown right after input transfer");

endmodule

bind cic_polyphase_interpolator_x4_unit cicpi_port_chk u_cicpi_port_chk (.*);
`default_nettype wire

>>> test/tb_cic_polyphase_interpolator_x4_unit.sv
// Testbench for the x4 polyphase CIC interpolator: predicted results checked per transfer.
`timescale 1ns / 1ps
`default_nettype none
module tb_cic_polyphase_interpolator_x4_unit;
  import cicpi_pkg::*;

  localparam int WATCHDOG_CYCLES = 20000;

  typedef struct packed {
    logic [TIME_W-1:0]          t;
    logic signed [SAMPLE_W-1:0] x;
    logic signed [SAMPLE_W-1:0] y;
    logic signed [SAMPLE_W-1:0] z;
    logic signed [SAMPLE_W-1:0] mag;
    logic                       last;
  } interp_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [TIME_W-1:0] in_time_tick = '0;
  logic signed [SAMPLE_W-1:0] in_accel_x = '0, in_accel_y = '0, in_accel_z = '0;
  logic signed [SAMPLE_W-1:0] in_accel_mag = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [TIME_W-1:0] out_time;
  logic signed [SAMPLE_W-1:0] out_x, out_y, out_z, out_mag;
  logic out_last_of_run;

  cic_polyphase_interpolator_x4_unit u_dut (.*);

  initial forever #2 clk = ~clk;

  // predictor state
  longint unsigned proto_taps [TAP_COUNT];
  longint hist_ring [CIC_ORDER][CHANNELS];
  int unsigned hist_wp = 0;
  int unsigned hist_fill = 0;
  interp_result_t expected_results [$];
  int unsigned fail_count = 0;
  int unsigned result_count = 0;
  int unsigned sent_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned stall_mode = 0;
  int unsigned burst_left = 0;

  function automatic void build_taps();
    longint unsigned tmp [TAP_COUNT];
    int len;
    len = 1;
    foreach (proto_taps[i]) proto_taps[i] = 0;
    proto_taps[0] = 1;
    for (int n = 0; n < CIC_ORDER; n++) begin
      foreach (tmp[i]) tmp[i] = 0;
      for (int i = 0; i < len; i++)
        for (int r = 0; r < RATE_FACTOR; r++)
          if (i + r < TAP_COUNT) tmp[i + r] += proto_taps[i];
      len += RATE_FACTOR - 1;
      foreach (tmp[i]) proto_taps[i] = tmp[i];
    end
  endfunction

  // round half up by 2^14, then clamp
  function automatic logic signed [SAMPLE_W-1:0] scale_round(longint acc);
    longint q;
    q = (acc + (64'sd1 <<< (SCALE_SH - 1))) >>> SCALE_SH;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return SAMPLE_W'(q);
  endfunction

  function automatic void predict_interp(logic [TIME_W-1:0] t,
                                         logic signed [SAMPLE_W-1:0] s [CHANNELS]);
    interp_result_t r;
    longint acc [CHANNELS];
    int unsigned pos, idx;
    for (int c = 0; c < CHANNELS; c++) hist_ring[hist_wp][c] = s[c];
    if (hist_fill <= CIC_ORDER) begin
      hist_fill++;
      hist_wp = (hist_wp + 1) % CIC_ORDER;
      return;
    end
    for (int k = 0; k < RATE_FACTOR; k++) begin
      for (int c = 0; c < CHANNELS; c++) begin
        acc[c] = 0;
        pos = hist_wp;
        for (int j = 0; j < CIC_ORDER; j++) begin
          idx = (RATE_FACTOR - 1 - k) + RATE_FACTOR * j;
          pos = (pos + 1) % CIC_ORDER;
          if (idx < TAP_COUNT) acc[c] += hist_ring[pos][c] * longint'(proto_taps[idx]);
        end
      end
      r.t = t - GROUP_DELAY + TIME_W'(k);
      r.x = scale_round(acc[0]);
      r.y = scale_round(acc[1]);
      r.z = scale_round(acc[2]);
      r.mag = scale_round(acc[3]);
      r.last = (k == RATE_FACTOR - 1);
      expected_results.push_back(r);
    end
    hist_wp = (hist_wp + 1) % CIC_ORDER;
  endfunction

  // valid stays high within a burst; before most new bursts it drops for a random gap
  task automatic send_set(logic [TIME_W-1:0] t, logic signed [SAMPLE_W-1:0] x,
                          logic signed [SAMPLE_W-1:0] y, logic signed [SAMPLE_W-1:0] z,
                          logic signed [SAMPLE_W-1:0] m);
    logic signed [SAMPLE_W-1:0] s [CHANNELS];
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 6);
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 40)) @(negedge clk);
      end
    end
    burst_left--;
    in_time_tick <= t;
    in_accel_x <= x;
    in_accel_y <= y;
    in_accel_z <= z;
    in_accel_mag <= m;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    s[0] = x; s[1] = y; s[2] = z; s[3] = m;
    predict_interp(t, s);
    sent_count++;
    @(negedge clk);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return SAMPLE_W'($urandom_range(0, 64)) - 16'sd32;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [TIME_W-1:0] rand_time();
    return {8'($urandom), 32'($urandom)};
  endfunction

  task automatic test_fill_and_extremes();
    send_set('0, 16'sh7fff, 16'sh8000, 16'sd0, -16'sd1);
    for (int i = 0; i < 9; i++) send_set(TIME_W'(i), 16'sh7fff, 16'sh8000, 16'sd0, -16'sd1);
    send_set(TIME_W'(5), 16'sh8000, 16'sh7fff, 16'sd1, 16'sd0);
    send_set({TIME_W{1'b1}}, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000);
    send_set(TIME_W'(11), 16'sh5555, 16'shaaaa, 16'sh00ff, 16'shff00);
  endtask

  task automatic test_impulse();
    send_set(TIME_W'(64), 16'sh4000, -16'sh4000, 16'sd1, -16'sd1);
    for (int i = 0; i < 8; i++) send_set(TIME_W'(65 + i), '0, '0, '0, '0);
  endtask

  task automatic test_random_sets(int n);
    for (int i = 0; i < n; i++)
      send_set(rand_time(), rand_sample(), rand_sample(), rand_sample(), rand_sample());
  endtask

  // receiver stall pattern, switches mode now and then
  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= ($urandom_range(0, 15) != 0);
    endcase
  end

  always @(posedge clk) begin
    interp_result_t e;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid && !out_stall) begin
        result_count++;
        if (expected_results.size() == 0) begin
          $error("unexpected result transfer, time %0h", out_time);
          fail_count++;
        end else begin
          e = expected_results.pop_front();
          if (out_time !== e.t) begin
            $error("out_time exp %0h got %0h", e.t, out_time); fail_count++;
          end
          if (out_x !== e.x) begin
            $error("out_x exp %0d got %0d", e.x, out_x); fail_count++;
          end
          if (out_y !== e.y) begin
            $error("out_y exp %0d got %0d", e.y, out_y); fail_count++;
          end
          if (out_z !== e.z) begin
            $error("out_z exp %0d got %0d", e.z, out_z); fail_count++;
          end
          if (out_mag !== e.mag) begin
            $error("out_mag exp %0d got %0d", e.mag, out_mag); fail_count++;
          end
          if (out_last_of_run !== e.last) begin
            $error("out_last_of_run exp %0b got %0b", e.last, out_last_of_run);
            fail_count++;
          end
        end
      end
      if (idle_cycles > WATCHDOG_CYCLES) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    build_taps();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_fill_and_extremes();
    test_impulse();
    test_random_sets(395);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Sent %0d sample sets, checked %0d interpolated results.", sent_count,
             result_count);
    if (fail_count == 0 && expected_results.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule
`default_nettype wire

>>> files.f
hw/rtl/cicpi_pkg.sv
hw/rtl/cicpi_lane.sv
hw/rtl/cic_polyphase_interpolator_x4_unit.sv
hw/rtl/cicpi_port_chk.sv
test/tb_cic_polyphase_interpolator_x4_unit.sv
